### rtl/cmf_pkg.sv
// cmf_pkg: shared types and constants of the cross mean filter
// used by cmf_ctrl, cmf_filter, cmf_line_mem and cross_mean_filter_top
// no dependencies
package cmf_pkg;

    // payload and register widths
    localparam int PIX_W     = 8;
    localparam int CFG_W     = 11;
    localparam int CFG_IDX_W = 1;

    // default size limits and reset frame size
    localparam int DEF_MAX_WIDTH    = 1024;
    localparam int DEF_MAX_HEIGHT   = 1024;
    localparam int RST_FRAME_WIDTH  = 640;
    localparam int RST_FRAME_HEIGHT = 480;

    // divide by five as multiply by reciprocal, exact for sums below 16384
    localparam int SUM_W      = 11;
    localparam int WSUM_W     = 10;
    localparam int DIV5_MUL_W = 13;
    localparam int DIV5_MUL   = 6554;
    localparam int DIV5_SHIFT = 15;

    // register indexes
    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_FRAME_WIDTH  = 1'b0,
        CFG_FRAME_HEIGHT = 1'b1
    } t_cfg_reg;

    // input command codes
    typedef enum logic {
        CMD_PIXEL = 1'b0,
        CMD_DRAIN = 1'b1
    } t_cmd;

    // per-beat decisions handed from control to datapath
    typedef struct packed {
        logic emit;        // beat produces a result
        logic pixel;       // pixel beat, writes the row stores
        logic sel_upper;   // drain result comes from upper store
        logic interior;    // result is the five-point mean
        logic single_col;  // frame is one column wide
        logic last;        // result is bottom right of the frame
    } t_item_ctrl;

endpackage

### rtl/cmf_line_mem.sv
// cmf_line_mem: one row store, one write port and one registered read port
// depends on cmf_pkg for the pixel width and the default depth
module cmf_line_mem #(
    parameter int DEPTH = cmf_pkg::DEF_MAX_WIDTH,
    localparam int AW   = $clog2(DEPTH)
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [AW-1:0]            i_waddr,
    input  logic [cmf_pkg::PIX_W-1:0] i_wdata,
    input  logic                     i_re,
    input  logic [AW-1:0]            i_raddr,
    output logic [cmf_pkg::PIX_W-1:0] o_rdata
);

    logic [cmf_pkg::PIX_W-1:0] r_mem [DEPTH];
    logic [cmf_pkg::PIX_W-1:0] r_rdata;

    // write port
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    // registered read port
    always_ff @(posedge i_clk) begin
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

### rtl/cmf_ctrl.sv
// cmf_ctrl: frame size registers, input and output raster positions, pending count
// decides per beat whether and how a result comes out; depends on cmf_pkg
module cmf_ctrl #(
    parameter int MAX_WIDTH  = cmf_pkg::DEF_MAX_WIDTH,
    parameter int MAX_HEIGHT = cmf_pkg::DEF_MAX_HEIGHT,
    localparam int CW        = $clog2(MAX_WIDTH)
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_cfg_we,
    input  logic [cmf_pkg::CFG_IDX_W-1:0] i_cfg_index,
    input  logic [cmf_pkg::CFG_W-1:0]     i_cfg_data,
    input  logic                          i_accept,
    input  logic                          i_command,
    output logic [CW-1:0]                 o_addr,
    output cmf_pkg::t_item_ctrl           o_item
);

    localparam int RW  = $clog2(MAX_HEIGHT);
    localparam int WW  = $clog2(MAX_WIDTH + 1);
    localparam int HW  = $clog2(MAX_HEIGHT + 1);
    localparam int PW  = $clog2(MAX_WIDTH + 2);
    localparam int WCW = (WW > cmf_pkg::CFG_W) ? WW : cmf_pkg::CFG_W;
    localparam int HCW = (HW > cmf_pkg::CFG_W) ? HW : cmf_pkg::CFG_W;
    localparam int WIDTH_RST  = (cmf_pkg::RST_FRAME_WIDTH > MAX_WIDTH) ?
                                MAX_WIDTH : cmf_pkg::RST_FRAME_WIDTH;
    localparam int HEIGHT_RST = (cmf_pkg::RST_FRAME_HEIGHT > MAX_HEIGHT) ?
                                MAX_HEIGHT : cmf_pkg::RST_FRAME_HEIGHT;

    logic [WW-1:0] r_width;
    logic [HW-1:0] r_height;
    logic [RW-1:0] r_in_row;
    logic [CW-1:0] r_in_col;
    logic [RW-1:0] r_out_row;
    logic [CW-1:0] r_out_col;
    logic [PW-1:0] r_pending;
    logic          r_draining;

    logic [WW-1:0] cfg_width;
    logic [HW-1:0] cfg_height;
    logic [WW-1:0] w_last;
    logic [HW-1:0] h_last;
    logic          is_drain;
    logic          restart;
    logic [PW-1:0] pend_use;
    logic [RW-1:0] orow_use;
    logic [CW-1:0] ocol_use;
    logic          pend_full;
    logic          drain_ok;
    logic          in_col_last;
    logic          in_row_last;
    logic          ocol_last;
    logic          orow_last;
    logic [RW-1:0] n_in_row;
    logic [CW-1:0] n_in_col;
    logic [RW-1:0] n_out_row;
    logic [CW-1:0] n_out_col;

    // clamp written sizes to 1..max
    always_comb begin
        if (i_cfg_data == '0) begin
            cfg_width  = WW'(1);
            cfg_height = HW'(1);
        end else begin
            if (WCW'(i_cfg_data) > WCW'(MAX_WIDTH)) begin
                cfg_width = WW'(MAX_WIDTH);
            end else begin
                cfg_width = WW'(i_cfg_data);
            end
            if (HCW'(i_cfg_data) > HCW'(MAX_HEIGHT)) begin
                cfg_height = HW'(MAX_HEIGHT);
            end else begin
                cfg_height = HW'(i_cfg_data);
            end
        end
    end

    // position bookkeeping
    always_comb begin
        w_last    = r_width - WW'(1);
        h_last    = r_height - HW'(1);
        is_drain  = (cmf_pkg::t_cmd'(i_command) == cmf_pkg::CMD_DRAIN);
        restart   = !is_drain && r_draining;
        pend_use  = restart ? '0 : r_pending;
        orow_use  = restart ? '0 : r_out_row;
        ocol_use  = restart ? '0 : r_out_col;
        pend_full = !(pend_use < (PW'(r_width) + PW'(1)));
        drain_ok  = is_drain && (r_in_row == '0) && (r_in_col == '0)
                    && (r_pending != '0);

        in_col_last = (WW'(r_in_col) == w_last);
        in_row_last = (HW'(r_in_row) == h_last);
        ocol_last   = (WW'(ocol_use) == w_last);
        orow_last   = (HW'(orow_use) == h_last);

        n_in_col  = in_col_last ? '0 : r_in_col + CW'(1);
        n_in_row  = in_col_last ? (in_row_last ? '0 : r_in_row + RW'(1)) : r_in_row;
        n_out_col = ocol_last ? '0 : ocol_use + CW'(1);
        n_out_row = ocol_last ? (orow_last ? '0 : orow_use + RW'(1)) : orow_use;
    end

    // beat decisions toward the datapath
    always_comb begin
        o_addr            = is_drain ? r_out_col : r_in_col;
        o_item.pixel      = !is_drain;
        o_item.emit       = is_drain ? drain_ok : pend_full;
        o_item.sel_upper  = (r_pending > PW'(r_width));
        o_item.single_col = (r_width == WW'(1));
        o_item.last       = orow_last && ocol_last;
        o_item.interior   = !is_drain && pend_full
                            && (orow_use != '0) && (HW'(orow_use) < h_last)
                            && (ocol_use != '0) && (WW'(ocol_use) < w_last);
    end

    // size registers and positions
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_width    <= WW'(WIDTH_RST);
            r_height   <= HW'(HEIGHT_RST);
            r_in_row   <= '0;
            r_in_col   <= '0;
            r_out_row  <= '0;
            r_out_col  <= '0;
            r_pending  <= '0;
            r_draining <= 1'b0;
        end else if (i_cfg_we) begin
            unique case (cmf_pkg::t_cfg_reg'(i_cfg_index))
                cmf_pkg::CFG_FRAME_WIDTH:  r_width  <= cfg_width;
                cmf_pkg::CFG_FRAME_HEIGHT: r_height <= cfg_height;
                default: ;
            endcase
            r_in_row   <= '0;
            r_in_col   <= '0;
            r_out_row  <= '0;
            r_out_col  <= '0;
            r_pending  <= '0;
            r_draining <= 1'b0;
        end else if (i_accept) begin
            if (is_drain) begin
                if (drain_ok) begin
                    r_pending  <= r_pending - PW'(1);
                    r_draining <= 1'b1;
                    r_out_row  <= n_out_row;
                    r_out_col  <= n_out_col;
                end
            end else begin
                r_draining <= 1'b0;
                r_in_row   <= n_in_row;
                r_in_col   <= n_in_col;
                if (pend_full) begin
                    r_pending <= pend_use;
                    r_out_row <= n_out_row;
                    r_out_col <= n_out_col;
                end else begin
                    r_pending <= pend_use + PW'(1);
                    r_out_row <= orow_use;
                    r_out_col <= ocol_use;
                end
            end
        end
    end

endmodule

### rtl/cmf_filter.sv
// cmf_filter: input stage with store read data, forwarding, pixel window,
// divide by five and the result register; depends on cmf_pkg
module cmf_filter #(
    parameter int MAX_WIDTH = cmf_pkg::DEF_MAX_WIDTH,
    localparam int CW       = $clog2(MAX_WIDTH)
) (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  logic                      i_accept,
    input  cmf_pkg::t_item_ctrl       i_item,
    input  logic [CW-1:0]             i_addr,
    input  logic [cmf_pkg::PIX_W-1:0] i_pixel,
    input  logic [cmf_pkg::PIX_W-1:0] i_up_rd,
    input  logic [cmf_pkg::PIX_W-1:0] i_mid_rd,
    input  logic                      i_out_stall,
    output logic                      o_in_stall,
    output logic                      o_we,
    output logic [CW-1:0]             o_waddr,
    output logic [cmf_pkg::PIX_W-1:0] o_up_wdata,
    output logic [cmf_pkg::PIX_W-1:0] o_mid_wdata,
    output logic                      o_out_valid,
    output logic [cmf_pkg::PIX_W-1:0] o_pixel_out,
    output logic                      o_frame_end
);

    localparam int PROD_W = cmf_pkg::SUM_W + cmf_pkg::DIV5_MUL_W;

    // input stage
    logic                      r_a_valid;
    cmf_pkg::t_item_ctrl       r_a_item;
    logic [CW-1:0]             r_a_addr;
    logic [cmf_pkg::PIX_W-1:0] r_a_pix;
    logic                      r_fwd;
    logic [cmf_pkg::PIX_W-1:0] r_fwd_up;
    logic [cmf_pkg::PIX_W-1:0] r_fwd_mid;

    // window of earlier pixel beats
    logic [cmf_pkg::PIX_W-1:0]  r_m1;
    logic [cmf_pkg::WSUM_W-1:0] r_wsum;

    // result register
    logic                      r_b_valid;
    logic [cmf_pkg::PIX_W-1:0] r_b_pix;
    logic                      r_b_last;

    logic                      b_free;
    logic                      a_adv;
    logic                      b_load;
    logic                      n_fwd;
    logic [cmf_pkg::PIX_W-1:0] eff_up;
    logic [cmf_pkg::PIX_W-1:0] eff_mid;
    logic [cmf_pkg::SUM_W-1:0] sum;
    logic [PROD_W-1:0]         prod;
    logic [cmf_pkg::PIX_W-1:0] quot;
    logic [cmf_pkg::PIX_W-1:0] n_value;

    // handshake
    always_comb begin
        b_free     = !r_b_valid || !i_out_stall;
        a_adv      = r_a_valid && (!r_a_item.emit || b_free);
        b_load     = a_adv && r_a_item.emit;
        o_in_stall = r_a_valid && !a_adv;
        n_fwd      = r_a_valid && r_a_item.pixel && (r_a_addr == i_addr);
    end

    // store values as seen after all earlier writes
    always_comb begin
        eff_up  = r_fwd ? r_fwd_up : i_up_rd;
        eff_mid = r_fwd ? r_fwd_mid : i_mid_rd;
    end

    // store update: upper takes old middle, middle takes the new pixel
    always_comb begin
        o_we        = a_adv && r_a_item.pixel;
        o_waddr     = r_a_addr;
        o_up_wdata  = eff_mid;
        o_mid_wdata = r_a_pix;
    end

    // five-point mean and result select
    always_comb begin
        sum  = cmf_pkg::SUM_W'(r_wsum) + cmf_pkg::SUM_W'(eff_mid);
        prod = PROD_W'(sum) * PROD_W'(cmf_pkg::DIV5_MUL);
        quot = prod[cmf_pkg::DIV5_SHIFT +: cmf_pkg::PIX_W];
        if (r_a_item.pixel) begin
            if (r_a_item.interior) begin
                n_value = quot;
            end else if (r_a_item.single_col) begin
                n_value = eff_up;
            end else begin
                n_value = r_m1;
            end
        end else begin
            n_value = r_a_item.sel_upper ? eff_up : eff_mid;
        end
    end

    // input stage control
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_a_valid <= 1'b0;
        end else if (i_accept) begin
            r_a_valid <= 1'b1;
        end else if (a_adv) begin
            r_a_valid <= 1'b0;
        end
    end

    // input stage payload and forwarded store values
    always_ff @(posedge i_clk) begin
        if (i_accept) begin
            r_a_item  <= i_item;
            r_a_addr  <= i_addr;
            r_a_pix   <= i_pixel;
            r_fwd     <= n_fwd;
            r_fwd_up  <= eff_mid;
            r_fwd_mid <= r_a_pix;
        end
    end

    // window shift on each pixel beat
    always_ff @(posedge i_clk) begin
        if (o_we) begin
            r_m1   <= eff_mid;
            r_wsum <= cmf_pkg::WSUM_W'(eff_mid) + cmf_pkg::WSUM_W'(r_m1)
                      + cmf_pkg::WSUM_W'(eff_up) + cmf_pkg::WSUM_W'(r_a_pix);
        end
    end

    // result register control
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_b_valid <= 1'b0;
        end else if (b_load) begin
            r_b_valid <= 1'b1;
        end else if (b_free) begin
            r_b_valid <= 1'b0;
        end
    end

    // result register payload
    always_ff @(posedge i_clk) begin
        if (b_load) begin
            r_b_pix  <= n_value;
            r_b_last <= r_a_item.last;
        end
    end

    assign o_out_valid = r_b_valid;
    assign o_pixel_out = r_b_pix;
    assign o_frame_end = r_b_last;

    // a held input beat keeps its address and pixel
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_a_valid && !a_adv |=> r_a_valid && $stable(r_a_addr) && $stable(r_a_pix))
        else $error("input stage lost a held beat");

    // an emitting beat that leaves the input stage lands in the result register
    b_catch: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        b_load |=> r_b_valid)
        else $error("result dropped between stages");

    // the mean is only taken for pixel beats that emit
    mean_kind: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_accept && i_item.interior |-> i_item.pixel && i_item.emit)
        else $error("interior flag on a non-emitting or drain beat");

    // the bottom right pixel is never interior
    last_edge: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_accept && i_item.last && i_item.emit |-> !i_item.interior)
        else $error("frame end marked as interior pixel");

endmodule

### rtl/cross_mean_filter_top.sv
// cross_mean_filter_top: top level of the five-point cross mean filter
// depends on cmf_pkg, cmf_ctrl, cmf_line_mem and cmf_filter
//
// Takes one beat per clock, pixels in raster order or drain steps, and keeps
// that rate as long as the output side is not stalled. Each beat is held in
// the input stage, where the two row stores return their registered read
// data, and each result then sits in the result register, which drives the
// outputs; in the stream a pixel's result appears frame_width + 1 pixel beats
// after the pixel itself. One read and one write port on each row store set
// the rate of one beat per cycle. Interior pixels get the truncated mean of
// the pixel and its four direct neighbors, border pixels pass unchanged;
// drain beats at the start of a frame push out the pending tail. The stores
// need no clearing after reset. Frame size writes belong in idle periods
// with no beat in flight, and they restart the frame.
module cross_mean_filter_top #(
    parameter int MAX_WIDTH  = cmf_pkg::DEF_MAX_WIDTH,
    parameter int MAX_HEIGHT = cmf_pkg::DEF_MAX_HEIGHT
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_cfg_we,
    input  logic [cmf_pkg::CFG_IDX_W-1:0] i_cfg_index,
    input  logic [cmf_pkg::CFG_W-1:0]     i_cfg_data,
    input  logic                          i_in_valid,
    output logic                          o_in_stall,
    input  logic                          i_command,
    input  logic [cmf_pkg::PIX_W-1:0]     i_pixel_in,
    output logic                          o_out_valid,
    input  logic                          i_out_stall,
    output logic [cmf_pkg::PIX_W-1:0]     o_pixel_out,
    output logic                          o_frame_end
);

    localparam int CW = $clog2(MAX_WIDTH);

    logic                      accept;
    logic [CW-1:0]             addr;
    cmf_pkg::t_item_ctrl       item;
    logic [cmf_pkg::PIX_W-1:0] up_rd;
    logic [cmf_pkg::PIX_W-1:0] mid_rd;
    logic                      we;
    logic [CW-1:0]             waddr;
    logic [cmf_pkg::PIX_W-1:0] up_wdata;
    logic [cmf_pkg::PIX_W-1:0] mid_wdata;

    // input beat taken
    assign accept = i_in_valid && !o_in_stall;

    // positions and per-beat decisions
    cmf_ctrl #(
        .MAX_WIDTH  (MAX_WIDTH),
        .MAX_HEIGHT (MAX_HEIGHT)
    ) u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .i_accept    (accept),
        .i_command   (i_command),
        .o_addr      (addr),
        .o_item      (item)
    );

    // older row store
    cmf_line_mem #(
        .DEPTH (MAX_WIDTH)
    ) u_upper (
        .i_clk   (i_clk),
        .i_we    (we),
        .i_waddr (waddr),
        .i_wdata (up_wdata),
        .i_re    (accept),
        .i_raddr (addr),
        .o_rdata (up_rd)
    );

    // newer row store
    cmf_line_mem #(
        .DEPTH (MAX_WIDTH)
    ) u_middle (
        .i_clk   (i_clk),
        .i_we    (we),
        .i_waddr (waddr),
        .i_wdata (mid_wdata),
        .i_re    (accept),
        .i_raddr (addr),
        .o_rdata (mid_rd)
    );

    // datapath and output register
    cmf_filter #(
        .MAX_WIDTH (MAX_WIDTH)
    ) u_filter (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_accept    (accept),
        .i_item      (item),
        .i_addr      (addr),
        .i_pixel     (i_pixel_in),
        .i_up_rd     (up_rd),
        .i_mid_rd    (mid_rd),
        .i_out_stall (i_out_stall),
        .o_in_stall  (o_in_stall),
        .o_we        (we),
        .o_waddr     (waddr),
        .o_up_wdata  (up_wdata),
        .o_mid_wdata (mid_wdata),
        .o_out_valid (o_out_valid),
        .o_pixel_out (o_pixel_out),
        .o_frame_end (o_frame_end)
    );

endmodule
